// File: rtl/sha1_pkg.sv
package sha1_pkg;

  localparam logic [31:0] H0 = 32'h6745_2301;
  localparam logic [31:0] H1 = 32'hefcd_ab89;
  localparam logic [31:0] H2 = 32'h98ba_dcfe;
  localparam logic [31:0] H3 = 32'h1032_5476;
  localparam logic [31:0] H4 = 32'hc3d2_e1f0;
  localparam logic [4:0][31:0] INIT_CV = {H4, H3, H2, H1, H0};

  localparam logic [31:0] K0 = 32'h5a82_7999;
  localparam logic [31:0] K1 = 32'h6ed9_eba1;
  localparam logic [31:0] K2 = 32'h8f1b_bcdc;
  localparam logic [31:0] K3 = 32'hca62_c1d6;

  localparam logic [7:0]  PAD_BYTE    = 8'h80;
  localparam logic [31:0] PAD_WORD    = {PAD_BYTE, 24'h0};
  localparam logic [2:0]  FULL_BYTES  = 3'd4;
  localparam logic [2:0]  MAX_BYTECNT = 3'd7;
  localparam logic [2:0]  LAST_IDX    = 3'd4;
  localparam logic [6:0]  LAST_ROUND  = 7'd79;
  localparam logic [3:0]  LAST_SLOT   = 4'd15;
  localparam logic [3:0]  LEN_HI_SLOT = 4'd14;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_FOLD,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    SRC_DATA,
    SRC_PADDED,
    SRC_PAD80,
    SRC_ZERO,
    SRC_LEN_HI,
    SRC_LEN_LO
  } word_src_t;

  typedef enum logic [1:0] {
    PH_CH,
    PH_PAR1,
    PH_MAJ,
    PH_PAR2
  } phase_t;

  typedef struct packed {
    logic       push;
    word_src_t  src;
    logic       count_bytes;
    logic       start;
    logic       round_en;
    phase_t     phase;
    logic       fold;
    logic       finish;
    logic [2:0] out_sel;
  } dp_cmd_t;

endpackage

// File: rtl/sha1_hash_engine.sv
// SHA-1 hash engine.
// Input channel (in_valid/in_ready): one beat carries data_word, first
// message byte in bits 31:24. Beats without last count as four bytes; the
// beat with last set carries 0..4 valid leading bytes in byte_count (larger
// values count as four), trailing bytes are dropped.
// Output channel (out_valid/out_ready): after a final beat, five beats of
// digest_word, word_index 0..4 (H0 first), last_word set on the fifth.
// Flow: a beat without last that does not fill the 16-word block leaves in_ready high.
// The beat filling a block holds off input while the 80 rounds run on the
// single round unit and the result is folded into the chaining values.
// A final beat then pushes padding one word per cycle (up to 16, plus a
// second block with another compression when the length field does
// not fit) before the digest appears.
// The output is not buffered past the five registered chaining words: a
// stalled receiver simply holds the block in its output state, and no new
// input is taken until the fifth digest beat goes.
// Reset (rst, synchronous) restores the initial chaining values and clears
// the word and byte counts; the same happens after every digest.
module sha1_hash_engine import sha1_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  dp_cmd_t cmd;

  // sequencing: block fill, padding, rounds, digest beats
  sha1_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .byte_count (byte_count),
    .last       (last),
    .out_ready  (out_ready),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .word_index (word_index),
    .last_word  (last_word),
    .cmd        (cmd)
  );

  // schedule window, working variables, chaining values, byte total
  sha1_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_word   (data_word),
    .byte_count  (byte_count),
    .last        (last),
    .digest_word (digest_word)
  );

endmodule

// File: rtl/sha1_ctrl.sv
module sha1_ctrl import sha1_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [2:0] byte_count,
  input  logic       last,
  input  logic       out_ready,
  output logic       in_ready,
  output logic       out_valid,
  output logic [2:0] word_index,
  output logic       last_word,
  output dp_cmd_t    cmd
);

  state_t     state, state_next;
  logic [3:0] count, count_next;
  logic [6:0] round, round_next;
  logic [2:0] idx, idx_next;
  logic       finishing, finishing_next;
  logic       pad80, pad80_next;
  logic       len_hi, len_hi_next;
  logic       full_last;

  assign full_last  = byte_count inside {[FULL_BYTES:MAX_BYTECNT]};
  assign in_ready   = (state == S_IDLE);
  assign out_valid  = (state == S_OUT);
  assign word_index = idx;
  assign last_word  = (idx == LAST_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      round     <= '0;
      idx       <= '0;
      finishing <= 1'b0;
      pad80     <= 1'b0;
      len_hi    <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      round     <= round_next;
      idx       <= idx_next;
      finishing <= finishing_next;
      pad80     <= pad80_next;
      len_hi    <= len_hi_next;
    end
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    round_next     = round;
    idx_next       = idx;
    finishing_next = finishing;
    pad80_next     = pad80;
    len_hi_next    = len_hi;
    cmd            = '0;
    cmd.src        = SRC_ZERO;
    cmd.out_sel    = idx;
    if (round < 7'd20) begin
      cmd.phase = PH_CH;
    end else if (round < 7'd40) begin
      cmd.phase = PH_PAR1;
    end else if (round < 7'd60) begin
      cmd.phase = PH_MAJ;
    end else begin
      cmd.phase = PH_PAR2;
    end

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.push        = 1'b1;
          cmd.count_bytes = 1'b1;
          cmd.src         = (last && !full_last) ? SRC_PADDED : SRC_DATA;
          finishing_next  = last;
          pad80_next      = last && full_last;
          count_next      = count + 4'd1;
          if (count == LAST_SLOT) begin
            cmd.start  = 1'b1;
            round_next = '0;
            state_next = S_ROUND;
          end else if (last) begin
            state_next = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.push   = 1'b1;
        count_next = count + 4'd1;
        if (pad80) begin
          cmd.src    = SRC_PAD80;
          pad80_next = 1'b0;
        end else if (len_hi) begin
          cmd.src = SRC_LEN_LO;
        end else if (count == LEN_HI_SLOT) begin
          cmd.src     = SRC_LEN_HI;
          len_hi_next = 1'b1;
        end else begin
          cmd.src = SRC_ZERO;
        end
        if (count == LAST_SLOT) begin
          cmd.start  = 1'b1;
          round_next = '0;
          state_next = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.round_en = 1'b1;
        round_next   = round + 7'd1;
        if (round == LAST_ROUND) begin
          state_next = S_FOLD;
        end
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        if (finishing && len_hi && !pad80 && count == '0) begin
          idx_next   = '0;
          state_next = S_OUT;
        end else if (finishing) begin
          state_next = S_PAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          idx_next = idx + 3'd1;
          if (idx == LAST_IDX) begin
            cmd.finish     = 1'b1;
            idx_next       = '0;
            count_next     = '0;
            finishing_next = 1'b0;
            pad80_next     = 1'b0;
            len_hi_next    = 1'b0;
            state_next     = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // a compression only starts on the push that fills the block
  a_start_full: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> (cmd.push && count == LAST_SLOT))
    else $error("compression started on a partial block");

  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while digest pending");

  a_back_to_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_word) |=> (in_ready && count == '0))
    else $error("no return to idle after final digest beat");

  a_plain_word: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !last && count != LAST_SLOT) |=> in_ready)
    else $error("stall after a word that did not fill the block");

endmodule

// File: rtl/sha1_dp.sv
module sha1_dp import sha1_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        last,
  output logic [31:0] digest_word
);

  logic [4:0][31:0] cv;
  logic [60:0]      total;
  logic [31:0]      w [16];
  logic [31:0]      a, b, c, d, e;

  logic [31:0] padded, push_word, sched, shift_in;
  logic [31:0] f, k, tmp;
  logic [63:0] bits;
  logic [2:0]  addend;

  assign bits   = {total, 3'b000};
  assign addend = (last && !(byte_count inside {[FULL_BYTES:MAX_BYTECNT]}))
                  ? byte_count : FULL_BYTES;

  // keep the leading valid bytes and place the pad byte after them
  always_comb begin
    case (byte_count[1:0])
      2'd0:    padded = PAD_WORD;
      2'd1:    padded = {data_word[31:24], PAD_BYTE, 16'h0};
      2'd2:    padded = {data_word[31:16], PAD_BYTE, 8'h0};
      default: padded = {data_word[31:8], PAD_BYTE};
    endcase
  end

  always_comb begin
    case (cmd.src)
      SRC_DATA:   push_word = data_word;
      SRC_PADDED: push_word = padded;
      SRC_PAD80:  push_word = PAD_WORD;
      SRC_LEN_HI: push_word = bits[63:32];
      SRC_LEN_LO: push_word = bits[31:0];
      default:    push_word = '0;
    endcase
  end

  // window holds W[t..t+15]; W[t+16] uses taps 0, 2, 8 and 13
  always_comb begin
    sched    = w[0] ^ w[2] ^ w[8] ^ w[13];
    sched    = {sched[30:0], sched[31]};
    shift_in = cmd.push ? push_word : sched;
  end

  always_comb begin
    case (cmd.phase)
      PH_CH: begin
        f = (b & c) | (~b & d);
        k = K0;
      end
      PH_PAR1: begin
        f = b ^ c ^ d;
        k = K1;
      end
      PH_MAJ: begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end
      default: begin
        f = b ^ c ^ d;
        k = K3;
      end
    endcase
    tmp = {a[26:0], a[31:27]} + f + e + k + w[0];
  end

  always_ff @(posedge clk) begin
    if (cmd.push || cmd.round_en) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= shift_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      a <= cv[0];
      b <= cv[1];
      c <= cv[2];
      d <= cv[3];
      e <= cv[4];
    end else if (cmd.round_en) begin
      e <= d;
      d <= c;
      c <= {b[1:0], b[31:2]};
      b <= a;
      a <= tmp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      cv    <= INIT_CV;
      total <= '0;
    end else begin
      if (cmd.fold) begin
        cv[0] <= cv[0] + a;
        cv[1] <= cv[1] + b;
        cv[2] <= cv[2] + c;
        cv[3] <= cv[3] + d;
        cv[4] <= cv[4] + e;
      end
      if (cmd.count_bytes) begin
        total <= total + {58'd0, addend};
      end
    end
  end

  always_comb begin
    case (cmd.out_sel)
      3'd0:    digest_word = cv[0];
      3'd1:    digest_word = cv[1];
      3'd2:    digest_word = cv[2];
      3'd3:    digest_word = cv[3];
      default: digest_word = cv[4];
    endcase
  end

endmodule

// File: bench/sha1_hash_engine_test.sv
module sha1_hash_engine_test;
  import sha1_pkg::*;

  // one expected digest beat
  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        fin;
  } digest_beat_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        last;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  // predictor state: chaining words, partial block, fill level, byte total
  logic [31:0] chain_h [5];
  logic [31:0] blk_words [16];
  int unsigned blk_fill;
  logic [60:0] msg_bytes;

  digest_beat_t digest_q [$];

  int unsigned mismatches;
  int unsigned beats_sent;
  int unsigned msgs_sent;
  int unsigned digests_checked;
  bit          steady_in;
  bit          steady_out;

  sha1_hash_engine i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_word  (data_word),
    .byte_count (byte_count),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .digest_word(digest_word),
    .word_index (word_index),
    .last_word  (last_word)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------
  // Digest predictor
  // ---------------------------------------------------------------------

  function automatic logic [31:0] rotl32(logic [31:0] x, int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void sha1_restart();
    for (int i = 0; i < 5; i++) chain_h[i] = INIT_CV[i];
    blk_fill  = 0;
    msg_bytes = '0;
  endfunction

  // 80 rounds over the buffered block, schedule kept in a rolling window
  function automatic void sha1_compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, wt, tmp;
    phase_t ph;
    w = blk_words;
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int t = 0; t < 80; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        wt = rotl32(w[t & 15] ^ w[(t - 14) & 15] ^ w[(t - 8) & 15] ^ w[(t - 3) & 15], 1);
        w[t & 15] = wt;
      end
      ph = phase_t'(t / 20);
      case (ph)
        PH_CH: begin
          f = (b & c) | (~b & d);
          k = K0;
        end
        PH_PAR1: begin
          f = b ^ c ^ d;
          k = K1;
        end
        PH_MAJ: begin
          f = (b & c) | (b & d) | (c & d);
          k = K2;
        end
        default: begin
          f = b ^ c ^ d;
          k = K3;
        end
      endcase
      tmp = rotl32(a, 5) + f + e + k + wt;
      e = d;
      d = c;
      c = rotl32(b, 30);
      b = a;
      a = tmp;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  function automatic void sha1_absorb_word(logic [31:0] w);
    blk_words[blk_fill] = w;
    blk_fill++;
    if (blk_fill == 16) begin
      sha1_compress();
      blk_fill = 0;
    end
  endfunction

  // One accepted input beat; a final beat pads, closes and queues the digest.
  function automatic void sha1_absorb_beat(logic [31:0] data, logic [2:0] cnt, logic lst);
    logic [2:0]  n;
    int unsigned nb;
    logic [31:0] mask;
    logic [31:0] w;
    logic [63:0] bit_len;
    if (!lst) begin
      msg_bytes = msg_bytes + 61'd4;
      sha1_absorb_word(data);
      return;
    end
    // byte counts above four saturate
    n  = (cnt > FULL_BYTES) ? FULL_BYTES : cnt;
    nb = n;
    msg_bytes = msg_bytes + 61'(nb);
    if (n == FULL_BYTES) begin
      sha1_absorb_word(data);
      w = PAD_WORD;
    end else begin
      // trailing bytes dropped, pad byte right behind the valid ones
      mask = (nb == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * nb));
      w = (data & mask) | (PAD_WORD >> (8 * nb));
    end
    sha1_absorb_word(w);
    // length field does not fit: zero-fill and run an extra block
    if (blk_fill > 14) begin
      while (blk_fill != 0) sha1_absorb_word(32'h0);
    end
    while (blk_fill < 14) sha1_absorb_word(32'h0);
    bit_len = {msg_bytes, 3'b000};
    sha1_absorb_word(bit_len[63:32]);
    sha1_absorb_word(bit_len[31:0]);
    for (int i = 0; i < 5; i++) begin
      digest_q.push_back('{word: chain_h[i], idx: 3'(i), fin: (i == LAST_IDX)});
    end
    sha1_restart();
  endfunction

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------

  // Sends one beat; in_valid is left high on return so back-to-back beats
  // need no second write in the same step.
  task automatic send_beat(logic [31:0] data, logic [2:0] cnt, logic lst);
    int unsigned gap;
    gap = steady_in ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_word  <= data;
    byte_count <= cnt;
    last       <= lst;
    do @(posedge clk); while (!in_ready);
    sha1_absorb_beat(data, cnt, lst);
    beats_sent++;
    if (lst) msgs_sent++;
  endtask

  // Body beats carry random data and a random (ignored) byte count.
  task automatic send_message(int unsigned nwords, logic [2:0] tail);
    steady_in = ($urandom_range(0, 3) == 0);
    for (int unsigned i = 0; i < nwords; i++) begin
      send_beat($urandom, 3'($urandom_range(0, 7)), 1'b0);
    end
    send_beat($urandom, tail, 1'b1);
  endtask

  // Drops valid and holds off until every queued digest beat has gone.
  task automatic drain_digests();
    in_valid <= 1'b0;
    do @(posedge clk); while (digest_q.size() != 0);
  endtask

  // ---------------------------------------------------------------------
  // Output side: stall draw per beat, occasional runs with ready held high
  // ---------------------------------------------------------------------

  initial begin
    int unsigned stall;
    out_ready <= 1'b0;
    steady_out = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 7) == 0) steady_out = !steady_out;
      stall = steady_out ? 0 : $urandom_range(0, 16);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Every digest beat against the oldest expectation
  always @(posedge clk) begin
    digest_beat_t exp_beat;
    if (!rst && out_valid && out_ready) begin
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("digest beat with nothing expected: %h/%0d/%0b",
                   digest_word, word_index, last_word);
        end
      end else begin
        exp_beat = digest_q.pop_front();
        digests_checked++;
        if (digest_word !== exp_beat.word || word_index !== exp_beat.idx ||
            last_word !== exp_beat.fin) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("digest beat mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                     exp_beat.word, exp_beat.idx, exp_beat.fin,
                     digest_word, word_index, last_word);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Single-beat messages with every tail length 0..4; all-ones data shows
  // that bytes past the count are dropped. Empty message included.
  task automatic test_tail_bytes();
    steady_in = 1'b0;
    for (int n = 0; n <= 4; n++) send_beat(32'hffff_ffff, 3'(n), 1'b1);
    send_beat(32'h0, FULL_BYTES, 1'b1);
  endtask

  // byte_count 5..7 on the final beat counts as four
  task automatic test_count_saturation();
    for (int n = 5; n <= 7; n++) send_beat($urandom, 3'(n), 1'b1);
    send_beat(32'h0, MAX_BYTECNT, 1'b1);
  endtask

  // byte_count on body beats has no effect; data extremes in the body
  task automatic test_ignored_count();
    send_beat(32'hffff_ffff, MAX_BYTECNT, 1'b0);
    send_beat(32'h0, 3'd0, 1'b0);
    send_beat(32'hffff_ffff, 3'd2, 1'b0);
    send_beat(32'h0, 3'd1, 1'b1);
  endtask

  // Messages ending right around the length-field boundary: pad word at slots
  // 12..15 or slot 0 of the next block, some needing the extra block, random content.
  task automatic test_pad_boundaries();
    for (int unsigned len = 12; len <= 15; len++) begin
      send_message(len, 3'($urandom_range(0, 3)));
      send_message(len, FULL_BYTES);
    end
  endtask

  // Random messages, half of them biased to block and padding boundaries
  task automatic test_random_messages();
    int unsigned len;
    while (beats_sent < 330) begin
      if ($urandom_range(0, 1)) len = 16 * $urandom_range(0, 1) + $urandom_range(12, 16);
      else len = $urandom_range(0, 40);
      send_message(len, 3'($urandom_range(0, 7)));
    end
  endtask

  // Sender waits for the digest to drain completely before each message
  task automatic test_drain_pause();
    for (int i = 0; i < 3; i++) begin
      drain_digests();
      send_message($urandom_range(0, 12), 3'($urandom_range(0, 7)));
    end
  endtask

  initial begin
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    data_word  <= '0;
    byte_count <= '0;
    last       <= 1'b0;
    mismatches      = 0;
    beats_sent      = 0;
    msgs_sent       = 0;
    digests_checked = 0;
    steady_in       = 1'b0;
    sha1_restart();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_tail_bytes();
    test_count_saturation();
    test_ignored_count();
    test_pad_boundaries();
    test_random_messages();
    test_drain_pause();

    // all beats in; wait out the digests, then a margin for stray output
    drain_digests();
    repeat (120) @(posedge clk);

    $display("covered %0d messages in %0d input beats, %0d digest words checked",
             msgs_sent, beats_sent, digests_checked);
    $display("tails 0..7, padding at every block boundary, random stalls both sides");
    if (mismatches == 0) begin
      $display("[sha1_hash_engine] OK");
    end else begin
      $display("[sha1_hash_engine] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #4000000;
    $display("[sha1_hash_engine] ERROR");
    $finish;
  end

endmodule

// File: sim.f
rtl/sha1_pkg.sv
rtl/sha1_ctrl.sv
rtl/sha1_dp.sv
rtl/sha1_hash_engine.sv
bench/sha1_hash_engine_test.sv
